FILE: hdl/sag_pkg.sv
// ----------------------------------------------------------------------------
// sag_pkg
// Shared types and constants for the stepper acceleration step generator.
// ----------------------------------------------------------------------------
`default_nettype none

package sag_pkg;

   localparam int unsigned DATA_W     = 32;
   localparam int unsigned SPR_W      = 16;
   localparam int unsigned RATE_W     = 24;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned RSP_DATA_W = 72;

   localparam int unsigned PROD_W     = DATA_W + RATE_W;
   localparam int unsigned DIV_QW     = PROD_W + 2;
   localparam int unsigned DIV_DW     = SPR_W + DATA_W;
   localparam int unsigned DIV_ITERS  = DIV_QW / 2;
   localparam int unsigned DIV_CNT_W  = $clog2(DIV_ITERS);

   localparam logic [SPR_W-1:0]  SPR_RESET       = 16'd200;
   localparam logic [RATE_W-1:0] MAX_SPEED_RESET = 24'd1280;
   localparam logic [RATE_W-1:0] ACCEL_RESET     = 24'd2560;
   localparam logic [DATA_W-1:0] START_IVL_RESET = 32'd10000;

   // speed increment = interval * accel * 4 / 15625 (Q16.8 rate to Q16.16 speed)
   localparam logic [DIV_DW-1:0] ACC_DIVISOR = 48'd15625;
   // interval = 1e6 * 65536 / (steps_per_rev * speed)
   localparam logic [DIV_QW-1:0] IVL_NUMERATOR = 58'd65536000000;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_STEPS_PER_REV = 3'd0,
      REG_MAX_SPEED     = 3'd1,
      REG_ACCEL         = 3'd2,
      REG_START_IVL     = 3'd3,
      REG_TURN_CW       = 3'd4,
      REG_DRIVE_EN      = 3'd5,
      REG_MODE_LEVEL    = 3'd6
   } csr_index_type;

   typedef enum logic [11:0] {
      ST_IDLE  = 12'b0000_0000_0001,
      ST_CHECK = 12'b0000_0000_0010,
      ST_MUL1  = 12'b0000_0000_0100,
      ST_LD1   = 12'b0000_0000_1000,
      ST_DIV1  = 12'b0000_0001_0000,
      ST_SPD   = 12'b0000_0010_0000,
      ST_MUL2  = 12'b0000_0100_0000,
      ST_LD2   = 12'b0000_1000_0000,
      ST_DIV2  = 12'b0001_0000_0000,
      ST_IVL   = 12'b0010_0000_0000,
      ST_NXT   = 12'b0100_0000_0000,
      ST_DONE  = 12'b1000_0000_0000
   } state_type;

   typedef struct packed {
      logic accept;
      logic mul_en;
      logic mul_sel;   // 0: interval * accel, 1: steps_per_rev * speed
      logic ld1;
      logic ld2;
      logic div_step;
      logic spd_upd;
      logic ivl_upd;
      logic nxt_upd;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic recompute;
      logic limit_ok;
      logic den_zero;
      logic div_last;
   } status_type;

   typedef struct packed {
      logic [SPR_W-1:0]  steps_per_rev;
      logic [RATE_W-1:0] max_speed;
      logic [RATE_W-1:0] accel;
   } cfg_type;

endpackage

`default_nettype wire

FILE: hdl/stepper_accel_step_generator.sv
// ----------------------------------------------------------------------------
// stepper_accel_step_generator
// Step generator with acceleration ramp for a stepper motor driver.
// ----------------------------------------------------------------------------
// Each request is a microsecond tick or a move. A move, or a tick that issues a
// step, recomputes timing: the speed ramp and the new step interval each take
// one pass of the shared two-bit-per-cycle divider; the interval division is
// skipped when its divisor is zero, and a move while above the speed limit
// skips both. One request is in work at a time; the next is taken while the
// previous result waits in the output register.
`default_nettype none

module stepper_accel_step_generator (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [sag_pkg::DATA_W-1:0]        req_tdata,  // step_delta
   input  wire logic [0:0]                        req_tuser,  // action
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // step_pulse, dir_level, enable_level, mode_pin, steps_pending[31:0],
   // gap_us[31:0], zero pad
   output logic [sag_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   input  wire logic                              csr_we,
   input  wire logic [sag_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [sag_pkg::DATA_W-1:0]        csr_wdata
);
   import sag_pkg::*;

   cmd_type           cmd;
   status_type        status;
   cfg_type           cfg;

   logic [SPR_W-1:0]  spr_ff;
   logic [RATE_W-1:0] max_speed_ff;
   logic [RATE_W-1:0] accel_ff;
   logic              turn_cw_ff;
   logic              drive_en_ff;
   logic              mode_ff;
   logic              ivl_wr;
   logic              out_free;
   logic              pulse;
   logic [DATA_W-1:0] steps;
   logic [DATA_W-1:0] gap;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         spr_ff       <= SPR_RESET;
         max_speed_ff <= MAX_SPEED_RESET;
         accel_ff     <= ACCEL_RESET;
         turn_cw_ff   <= 1'b1;
         drive_en_ff  <= 1'b1;
         mode_ff      <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            REG_STEPS_PER_REV: spr_ff       <= csr_wdata[SPR_W-1:0];
            REG_MAX_SPEED:     max_speed_ff <= csr_wdata[RATE_W-1:0];
            REG_ACCEL:         accel_ff     <= csr_wdata[RATE_W-1:0];
            REG_TURN_CW:       turn_cw_ff   <= csr_wdata[0];
            REG_DRIVE_EN:      drive_en_ff  <= csr_wdata[0];
            REG_MODE_LEVEL:    mode_ff      <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign ivl_wr            = csr_we && (csr_index == REG_START_IVL);
   assign cfg.steps_per_rev = spr_ff;
   assign cfg.max_speed     = max_speed_ff;
   assign cfg.accel         = accel_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   sag_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .out_free  (out_free),
      .status    (status),
      .cmd       (cmd)
   );

   sag_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .cfg        (cfg),
      .ivl_wr     (ivl_wr),
      .ivl_wdata  (csr_wdata),
      .req_action (req_tuser[0]),
      .req_delta  (req_tdata),
      .pulse      (pulse),
      .steps      (steps),
      .gap        (gap)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{(RSP_DATA_W - 2*DATA_W - 4){1'b0}}, gap, steps,
                         mode_ff, drive_en_ff, turn_cw_ff, pulse};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: hdl/sag_ctrl.sv
// ----------------------------------------------------------------------------
// sag_ctrl
// Sequencer: walks each request through update and, when timing is recomputed,
// speed ramp and interval division, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sag_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                out_free,
   input  wire sag_pkg::status_type status,
   output sag_pkg::cmd_type         cmd
);
   import sag_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!status.recompute) begin
               state_in = ST_DONE;
            end else if (!status.limit_ok) begin
               state_in = ST_NXT;
            end else begin
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_LD1;
         end
         ST_LD1: begin
            cmd.ld1  = 1'b1;
            state_in = ST_DIV1;
         end
         ST_DIV1: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_SPD;
            end
         end
         ST_SPD: begin
            cmd.spd_upd = 1'b1;
            state_in    = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = 1'b1;
            state_in    = ST_LD2;
         end
         ST_LD2: begin
            cmd.ld2  = 1'b1;
            state_in = status.den_zero ? ST_NXT : ST_DIV2;
         end
         ST_DIV2: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_IVL;
            end
         end
         ST_IVL: begin
            cmd.ivl_upd = 1'b1;
            state_in    = ST_NXT;
         end
         ST_NXT: begin
            cmd.nxt_upd = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hdl/sag_dp.sv
// ----------------------------------------------------------------------------
// sag_dp
// Datapath: motion state, shared multiplier and a radix-4 restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module sag_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sag_pkg::cmd_type              cmd,
   output sag_pkg::status_type                status,
   input  wire sag_pkg::cfg_type              cfg,
   input  wire logic                          ivl_wr,
   input  wire logic [sag_pkg::DATA_W-1:0]    ivl_wdata,
   input  wire logic                          req_action,
   input  wire logic [sag_pkg::DATA_W-1:0]    req_delta,
   output logic                               pulse,
   output logic [sag_pkg::DATA_W-1:0]         steps,
   output logic [sag_pkg::DATA_W-1:0]         gap
);
   import sag_pkg::*;

   logic [DATA_W-1:0]    now_ff, now_in;
   logic [DATA_W-1:0]    next_ff, next_in;
   logic [DATA_W-1:0]    steps_ff, steps_in;
   logic [DATA_W-1:0]    speed_ff, speed_in;
   logic [DATA_W-1:0]    ivl_ff, ivl_in;
   logic                 pulse_ff, pulse_in;
   logic                 rec_ff, rec_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [DIV_DW-1:0]    rem_ff, rem_in;
   logic [DIV_QW-1:0]    quo_ff, quo_in;
   logic [DIV_DW-1:0]    dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   logic [DATA_W-1:0]    now_inc;
   logic [DATA_W:0]      steps_sum;
   logic                 fire;
   logic [DATA_W-1:0]    mul_a;
   logic [RATE_W-1:0]    mul_b;
   logic [DIV_DW:0]      t1, t2, r1, r2;
   logic                 ge1, ge2;
   logic [DATA_W:0]      spd_sum;
   logic                 quo_high;

   assign now_inc   = now_ff + 1'b1;
   assign steps_sum = {steps_ff[DATA_W-1], steps_ff} + {req_delta[DATA_W-1], req_delta};
   assign fire      = !steps_ff[DATA_W-1] && (steps_ff != '0) && (next_ff < now_inc);

   assign mul_a   = cmd.mul_sel ? speed_ff : ivl_ff;
   assign mul_b   = cmd.mul_sel ? {{(RATE_W-SPR_W){1'b0}}, cfg.steps_per_rev} : cfg.accel;
   assign prod_in = cmd.mul_en ? PROD_W'(mul_a * mul_b) : prod_ff;

   // two quotient bits per cycle
   always_comb begin
      t1  = {rem_ff, quo_ff[DIV_QW-1]};
      ge1 = (t1 >= {1'b0, dvs_ff});
      r1  = ge1 ? (t1 - {1'b0, dvs_ff}) : t1;
      t2  = {r1[DIV_DW-1:0], quo_ff[DIV_QW-2]};
      ge2 = (t2 >= {1'b0, dvs_ff});
      r2  = ge2 ? (t2 - {1'b0, dvs_ff}) : t2;
   end

   assign quo_high = |quo_ff[DIV_QW-1:DATA_W];
   assign spd_sum  = {1'b0, speed_ff} + {1'b0, quo_ff[DATA_W-1:0]};

   always_comb begin
      now_in   = now_ff;
      next_in  = next_ff;
      steps_in = steps_ff;
      speed_in = speed_ff;
      ivl_in   = ivl_ff;
      pulse_in = pulse_ff;
      rec_in   = rec_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      cnt_in   = cnt_ff;
      if (cmd.accept) begin
         pulse_in = 1'b0;
         if (req_action) begin
            rec_in = 1'b1;
            if (steps_sum[DATA_W] != steps_sum[DATA_W-1]) begin
               steps_in = steps_sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                            : {1'b0, {(DATA_W-1){1'b1}}};
            end else begin
               steps_in = steps_sum[DATA_W-1:0];
            end
         end else begin
            now_in   = now_inc;
            rec_in   = fire;
            pulse_in = fire;
            if (fire) begin
               steps_in = steps_ff - 1'b1;
            end
         end
      end
      if (cmd.ld1) begin
         rem_in = '0;
         quo_in = {prod_ff, 2'b00};
         dvs_in = ACC_DIVISOR;
         cnt_in = '0;
      end
      if (cmd.ld2) begin
         rem_in = '0;
         quo_in = IVL_NUMERATOR;
         dvs_in = prod_ff[DIV_DW-1:0];
         cnt_in = '0;
         if (status.den_zero) begin
            ivl_in = '1;
         end
      end
      if (cmd.div_step) begin
         rem_in = r2[DIV_DW-1:0];
         quo_in = {quo_ff[DIV_QW-3:0], ge1, ge2};
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.spd_upd) begin
         speed_in = (quo_high || spd_sum[DATA_W]) ? '1 : spd_sum[DATA_W-1:0];
      end
      if (cmd.ivl_upd) begin
         ivl_in = quo_high ? '1 : quo_ff[DATA_W-1:0];
      end
      if (cmd.nxt_upd) begin
         next_in = now_ff + ivl_ff;
      end
      if (ivl_wr) begin
         ivl_in = ivl_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff   <= '0;
         next_ff  <= '0;
         steps_ff <= '0;
         speed_ff <= '0;
         ivl_ff   <= START_IVL_RESET;
         pulse_ff <= 1'b0;
         rec_ff   <= 1'b0;
      end else begin
         now_ff   <= now_in;
         next_ff  <= next_in;
         steps_ff <= steps_in;
         speed_ff <= speed_in;
         ivl_ff   <= ivl_in;
         pulse_ff <= pulse_in;
         rec_ff   <= rec_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      cnt_ff  <= cnt_in;
   end

   assign status.recompute = rec_ff;
   assign status.limit_ok  = (speed_ff <= {cfg.max_speed, 8'h00});
   assign status.den_zero  = (prod_ff[DIV_DW-1:0] == '0);
   assign status.div_last  = (cnt_ff == DIV_CNT_W'(DIV_ITERS - 1));

   assign pulse = pulse_ff;
   assign steps = steps_ff;
   assign gap   = ivl_ff;

endmodule

`default_nettype wire

FILE: hdl/sag_checker.sv
// ----------------------------------------------------------------------------
// sag_checker
// Port-level checks for the step generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sag_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   input  wire logic                          req_tready,
   input  wire logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   input  wire logic [sag_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import sag_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // one request in work at a time
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // a step only leaves a non-negative count
   a_pulse_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> !rsp_tdata[DATA_W+3])
      else $error("step issued with negative count");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:2*DATA_W+4] == '0)
      else $error("pad bits set");

endmodule

bind stepper_accel_step_generator sag_checker u_sag_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
